// ----- hdl/cidr_port_rule_first_match_unit_macros.svh -----
// Assertion macros for the CIDR port rule first-match unit.
// No dependencies; included by the top level only.
`ifndef CIDR_PORT_RULE_FIRST_MATCH_UNIT_MACROS_SVH
`define CIDR_PORT_RULE_FIRST_MATCH_UNIT_MACROS_SVH
`ifndef SYNTH
`define CPRFM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPRFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPRFM_ASSERT_IMPL(lbl, ante, cons)
`define CPRFM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/cprfm_pkg.sv -----
// Shared types, request codes and prefix helpers for the rule classifier.
// No dependencies; used by cprfm_rule_mem and the top level.
package cprfm_pkg;

  localparam int RULES_DEF      = 16;
  localparam int PORT_PAIRS_DEF = 4;

  localparam logic [2:0] REQ_HDR    = 3'd0;
  localparam logic [2:0] REQ_BASE   = 3'd1;
  localparam logic [2:0] REQ_EXCEPT = 3'd2;
  localparam logic [2:0] REQ_PORT   = 3'd3;
  localparam logic [2:0] REQ_LOOKUP = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         slot;
    logic [2:0]         port_slot;
    logic               is_v6;
    logic [7:0]         prefix_len;
    logic [7:0]         except_len;
    logic signed [15:0] order_index;
    logic [63:0]        addr_hi;
    logic [63:0]        addr_lo;
    logic [15:0]        port_low;
    logic [15:0]        port_high;
    logic signed [15:0] limit_order;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [3:0]         rule_slot;
    logic signed [15:0] rule_order;
  } out_t;

  typedef struct packed {
    logic [2:0]         port_cnt;
    logic signed [15:0] order;
    logic [7:0]         except_len;
    logic [7:0]         prefix_len;
    logic               is_v6;
  } hdr_t;

  typedef struct packed {
    hdr_t         hdr;
    logic [127:0] base;
    logic [127:0] excl;
  } rule_t;

  // Top-aligned mask of the clamped prefix length.
  function automatic logic [127:0] pfx_mask(input logic [7:0] len, input logic v6);
    logic [7:0] clen;
    clen = len;
    if (v6 && len > 8'd128) clen = 8'd128;
    if (!v6 && len > 8'd32) clen = 8'd32;
    return ~({128{1'b1}} >> clen);
  endfunction

  function automatic logic pfx_covers(input logic [127:0] addr, input logic [127:0] base,
                                      input logic [7:0] len, input logic v6);
    return ((addr ^ base) & pfx_mask(len, v6)) == '0;
  endfunction

endpackage

// ----- hdl/cprfm_rule_mem.sv -----
// Rule tables: header, base address, except address and port range memories.
// Depends on cprfm_pkg; decodes load transfers and serves one registered read.
module cprfm_rule_mem #(
  parameter int RULES      = cprfm_pkg::RULES_DEF,
  parameter int PORT_PAIRS = cprfm_pkg::PORT_PAIRS_DEF,
  localparam int SLOT_W    = (RULES > 1) ? $clog2(RULES) : 1,
  localparam int PP_W      = (PORT_PAIRS > 1) ? $clog2(PORT_PAIRS) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  cprfm_pkg::in_t               wr_item,
  input  logic                         rd_en,
  input  logic [SLOT_W-1:0]            rd_addr,
  output cprfm_pkg::rule_t             rd_rule,
  output logic [PORT_PAIRS-1:0][31:0]  rd_ports
);

  cprfm_pkg::hdr_t             hdr_mem  [RULES];
  logic [127:0]                base_mem [RULES];
  logic [127:0]                excl_mem [RULES];
  logic [PORT_PAIRS-1:0][31:0] port_mem [RULES];

  logic              slot_ok;
  logic              lane_ok;
  logic [SLOT_W-1:0] wr_row;
  logic [PP_W-1:0]   wr_lane;
  logic [15:0]       rng_lo;
  logic [15:0]       rng_hi;
  cprfm_pkg::hdr_t   wr_hdr;

  always_comb begin
    slot_ok = int'(wr_item.slot) < RULES;
    lane_ok = int'(wr_item.port_slot) < PORT_PAIRS;
    wr_row  = SLOT_W'(wr_item.slot);
    wr_lane = PP_W'(wr_item.port_slot);
    // store reversed ranges swapped
    if (wr_item.port_low > wr_item.port_high) begin
      rng_lo = wr_item.port_high;
      rng_hi = wr_item.port_low;
    end else begin
      rng_lo = wr_item.port_low;
      rng_hi = wr_item.port_high;
    end
    wr_hdr.port_cnt   = wr_item.port_slot;
    wr_hdr.order      = wr_item.order_index;
    wr_hdr.except_len = wr_item.except_len;
    wr_hdr.prefix_len = wr_item.prefix_len;
    wr_hdr.is_v6      = wr_item.is_v6;
  end

  always_ff @(posedge clk) begin
    if (wr_en && slot_ok) begin
      if (wr_item.req_type == cprfm_pkg::REQ_HDR) begin
        hdr_mem[wr_row] <= wr_hdr;
      end
      if (wr_item.req_type == cprfm_pkg::REQ_BASE) begin
        base_mem[wr_row] <= {wr_item.addr_hi, wr_item.addr_lo};
      end
      if (wr_item.req_type == cprfm_pkg::REQ_EXCEPT) begin
        excl_mem[wr_row] <= {wr_item.addr_hi, wr_item.addr_lo};
      end
      if (wr_item.req_type == cprfm_pkg::REQ_PORT && lane_ok) begin
        port_mem[wr_row][wr_lane] <= {rng_hi, rng_lo};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rule.hdr  <= hdr_mem[rd_addr];
      rd_rule.base <= base_mem[rd_addr];
      rd_rule.excl <= excl_mem[rd_addr];
      rd_ports     <= port_mem[rd_addr];
    end
  end

endmodule

// ----- hdl/cidr_port_rule_first_match_unit.sv -----
// Lookup: n = min(rule_count, RULES) rules, one read per cycle; stopping at
// rule k (k < n), out_valid rises and busy drops on the same edge, so busy is
// low in the strobe cycle. With n = 0 no scan runs and the registered strobe
// follows the transfer without raising busy. Loads do not raise busy.
// Receiver cannot stall. Sync active-low reset clears rule_count and control.
// Depends on cprfm_pkg, cprfm_rule_mem and the assertion macro header.
`include "cidr_port_rule_first_match_unit_macros.svh"

module cidr_port_rule_first_match_unit #(
  parameter int RULES      = cprfm_pkg::RULES_DEF,
  parameter int PORT_PAIRS = cprfm_pkg::PORT_PAIRS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cprfm_pkg::in_t   in_data,
  output logic             out_valid,
  output cprfm_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data
);

  localparam int SLOT_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W  = $clog2(RULES + 1);

  cprfm_pkg::state_t state_r, state_nxt;

  logic [4:0]       rule_count_r;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] rd_slot_r;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_en;
  cprfm_pkg::in_t   lk_r;

  cprfm_pkg::rule_t            rd_rule;
  logic [PORT_PAIRS-1:0][31:0] rd_ports;

  logic            accept;
  logic            lookup_acc;
  logic            load_acc;
  logic [127:0]    lk_addr;
  logic            order_stop;
  logic            port_ok;
  logic            match;
  logic            last;
  logic            stop;
  logic            out_valid_r, out_valid_nxt;
  cprfm_pkg::out_t out_r, out_nxt;

  assign accept     = start && !busy;
  assign lookup_acc = accept && in_data.req_type == cprfm_pkg::REQ_LOOKUP;
  assign load_acc   = accept && in_data.req_type != cprfm_pkg::REQ_LOOKUP;
  assign cnt_eff    = (int'(rule_count_r) > RULES) ? CNT_W'(RULES) : CNT_W'(rule_count_r);
  // hold the count steady while a transfer is offered
  assign cfg_ready  = !busy && !start;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  cprfm_rule_mem #(
    .RULES      (RULES),
    .PORT_PAIRS (PORT_PAIRS)
  ) u_mem (
    .clk      (clk),
    .wr_en    (load_acc),
    .wr_item  (in_data),
    .rd_en    (rd_en),
    .rd_addr  (idx_r[SLOT_W-1:0]),
    .rd_rule  (rd_rule),
    .rd_ports (rd_ports)
  );

  // Evaluate the rule read in the previous cycle.
  always_comb begin
    lk_addr    = {lk_r.addr_hi, lk_r.addr_lo};
    order_stop = rd_rule.hdr.order >= lk_r.limit_order;
    port_ok    = 1'b0;
    for (int k = 0; k < PORT_PAIRS; k++) begin
      if (k < int'(rd_rule.hdr.port_cnt) && lk_r.port_low >= rd_ports[k][15:0]
          && lk_r.port_low <= rd_ports[k][31:16]) begin
        port_ok = 1'b1;
      end
    end
    match = !order_stop && rd_rule.hdr.is_v6 == lk_r.is_v6
            && cprfm_pkg::pfx_covers(lk_addr, rd_rule.base, rd_rule.hdr.prefix_len,
                                     lk_r.is_v6)
            && port_ok
            && !(rd_rule.hdr.except_len != 8'd0
                 && cprfm_pkg::pfx_covers(lk_addr, rd_rule.excl, rd_rule.hdr.except_len,
                                          lk_r.is_v6));
    last  = rd_slot_r == cnt_eff - CNT_W'(1);
    stop  = rd_vld_r && (order_stop || match || last);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cprfm_pkg::ST_IDLE: begin
        if (lookup_acc && cnt_eff != '0) state_nxt = cprfm_pkg::ST_SCAN;
      end
      cprfm_pkg::ST_SCAN: begin
        if (stop) state_nxt = cprfm_pkg::ST_IDLE;
      end
      default: state_nxt = cprfm_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    busy          = state_r == cprfm_pkg::ST_SCAN;
    rd_en         = busy && idx_r < cnt_eff;
    idx_nxt       = rd_en ? idx_r + CNT_W'(1) : idx_r;
    rd_vld_nxt    = rd_en && !stop;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    unique case (state_r)
      cprfm_pkg::ST_IDLE: begin
        idx_nxt       = '0;
        rd_vld_nxt    = 1'b0;
        out_valid_nxt = lookup_acc && cnt_eff == '0;
      end
      cprfm_pkg::ST_SCAN: begin
        out_valid_nxt = stop;
        if (match) begin
          out_nxt.hit        = 1'b1;
          out_nxt.rule_slot  = 4'(rd_slot_r);
          out_nxt.rule_order = rd_rule.hdr.order;
        end
      end
      default: begin
        idx_nxt    = '0;
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cprfm_pkg::ST_IDLE;
      rule_count_r <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) rule_count_r <= cfg_data;
    end
  end

  // Payload: hold lookup key, track slot in flight, capture result.
  always_ff @(posedge clk) begin
    if (lookup_acc) lk_r <= in_data;
    rd_slot_r <= idx_r;
    out_r     <= out_nxt;
  end

  `CPRFM_ASSERT_IMPL(a_nohit_zero, out_valid && !out_data.hit, out_data.rule_slot == '0 && out_data.rule_order == '0)
  `CPRFM_ASSERT_NEXT(a_scan_busy, lookup_acc && cnt_eff != '0, busy)
  `CPRFM_ASSERT_IMPL(a_slot_range, rd_vld_r, rd_slot_r < cnt_eff)
  `CPRFM_ASSERT_IMPL(a_strobe_src, out_valid, $past(busy) || $past(lookup_acc))

endmodule
